@@ src/etee_pkg.sv @@
`default_nettype none

package etee_pkg;

   // Event kinds carried on req_tuser
   typedef enum logic [1:0] {
      KIND_KEY   = 2'd0,
      KIND_CLICK = 2'd1,
      KIND_OTHER = 2'd2
   } event_kind_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_MAX_TIMER_BITS = 1'b0,
      CSR_COARSE_TIMER   = 1'b1
   } csr_index_type;

   localparam int unsigned REQ_TDATA_W = 144;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned RSP_TUSER_W = 1;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [4:0]  TIMER_BITS_RESET = 5'd8;
   localparam logic [2:0]  DERATE_SHIFT     = 3'd4;
   localparam logic [31:0] MIN_DELTA        = 32'd1 << (DERATE_SHIFT + 3'd1);
   localparam logic [31:0] DELTA_CAP        = 32'hffff_ffff;
   localparam logic [10:0] MAX_CREDIT       = 11'd1050;

endpackage

`default_nettype wire

@@ src/event_timing_entropy_estimator.sv @@
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless rsp_ stalls; these two registers move
// together, so a stalled result only holds the input once both are full.
// The quotient for coarse mode comes from one 32 x 33 reciprocal multiply.
// Synchronous active-high reset empties both stages, clears the timestamp and
// all histories to zero and returns the registers to max 8 bits, fine timer.
`default_nettype none

module event_timing_entropy_estimator #(
   parameter int unsigned COARSE_DIVISOR = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: key_code[31:0], click_position[63:32], timestamp[127:64],
   // base_bits[137:128], zero padding above
   input  wire logic [etee_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: event_kind[1:0]
   input  wire logic [etee_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata: credited_bits[10:0], zero padding above
   output logic [etee_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // rsp_tuser: dropped[0]
   output logic [etee_pkg::RSP_TUSER_W-1:0]        rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [etee_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [etee_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import etee_pkg::*;

   // Exact divide of a 32-bit value by the constant divisor
   localparam int unsigned DivShift  = $clog2(COARSE_DIVISOR);
   localparam int unsigned ProdShift = 32 + DivShift;
   localparam logic [64:0] DivRecipWide =
      ((65'd1 << ProdShift) + 65'(COARSE_DIVISOR) - 65'd1) / 65'(COARSE_DIVISOR);
   localparam logic [32:0] DivRecip = DivRecipWide[32:0];

   function automatic logic [4:0] floor_log2(input logic [31:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 1; i < 32; i++) begin
         if (v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

   // Configuration
   logic [4:0] max_timer_bits_ff;
   logic       coarse_timer_ff;

   // Input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic [31:0] s1_key_ff;
   logic [31:0] s1_pos_ff;
   logic [31:0] s1_delta_ff;
   logic [9:0]  s1_base_ff;
   logic [63:0] last_time_ff;

   // History
   logic [31:0] key0_ff, key1_ff, pos0_ff, pos1_ff, dlt0_ff, dlt1_ff;

   // Result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_credit_ff, rsp_credit_in;
   logic        rsp_drop_ff, rsp_drop_in;

   logic        accept, advance;
   logic [63:0] diff;
   logic [31:0] delta_sat;
   logic [64:0] prod;
   logic [31:0] dq;
   logic        key_hit, pos_hit, drop, credit_ok;
   logic [4:0]  tbits, tmin;

   assign accept     = req_tvalid && req_tready;
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Wrapped difference to the previous timestamp, saturated to 32 bits
   assign diff      = req_tdata[127:64] - last_time_ff;
   assign delta_sat = (diff[63:32] != 32'd0) ? DELTA_CAP : diff[31:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Repeat check, derate and timing credit
   assign key_hit = (s1_key_ff == key0_ff) && (s1_key_ff == key1_ff);
   assign pos_hit = (s1_pos_ff == pos0_ff) && (s1_pos_ff == pos1_ff);
   assign drop    = ((s1_kind_ff == KIND_KEY) && key_hit) ||
                    ((s1_kind_ff == KIND_CLICK) && pos_hit);

   assign prod = {33'd0, s1_delta_ff} * {32'd0, DivRecip};
   assign dq   = coarse_timer_ff ? 32'(prod >> ProdShift) : s1_delta_ff;

   assign credit_ok = !drop && (dq >= MIN_DELTA) && !((dq == dlt0_ff) && (dq == dlt1_ff));
   assign tbits     = floor_log2(dq) - 5'(DERATE_SHIFT);
   assign tmin      = (tbits < max_timer_bits_ff) ? tbits : max_timer_bits_ff;

   always_comb begin
      rsp_credit_in = 11'd0;
      rsp_drop_in   = drop;
      if (!drop) begin
         rsp_credit_in = {1'b0, s1_base_ff} + (credit_ok ? {6'd0, tmin} : 11'd0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         last_time_ff      <= 64'd0;
         key0_ff           <= 32'd0;
         key1_ff           <= 32'd0;
         pos0_ff           <= 32'd0;
         pos1_ff           <= 32'd0;
         dlt0_ff           <= 32'd0;
         dlt1_ff           <= 32'd0;
         max_timer_bits_ff <= TIMER_BITS_RESET;
         coarse_timer_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            last_time_ff <= req_tdata[127:64];
         end
         // Shift histories as the item leaves the input stage
         if (advance) begin
            if ((s1_kind_ff == KIND_KEY) && !key_hit) begin
               key1_ff <= key0_ff;
               key0_ff <= s1_key_ff;
            end
            if ((s1_kind_ff == KIND_CLICK) && !pos_hit) begin
               pos1_ff <= pos0_ff;
               pos0_ff <= s1_pos_ff;
            end
            if (credit_ok) begin
               dlt1_ff <= dlt0_ff;
               dlt0_ff <= dq;
            end
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MAX_TIMER_BITS: max_timer_bits_ff <= csr_wdata;
               CSR_COARSE_TIMER:   coarse_timer_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_tuser;
         s1_key_ff   <= req_tdata[31:0];
         s1_pos_ff   <= req_tdata[63:32];
         s1_delta_ff <= delta_sat;
         s1_base_ff  <= req_tdata[137:128];
      end
      if (advance) begin
         rsp_credit_ff <= rsp_credit_in;
         rsp_drop_ff   <= rsp_drop_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_credit_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule

`default_nettype wire

@@ src/etee_checker.sv @@
`default_nettype none

module etee_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic [etee_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic [etee_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready
);
   import etee_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // A dropped item carries no credit
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("dropped item with non-zero credit");

   // Credit stays within base plus largest timing term
   a_credit_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= RSP_TDATA_W'(MAX_CREDIT))
      else $error("credit above limit");

   // An empty result register never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item present after reset");

endmodule

bind event_timing_entropy_estimator etee_checker u_etee_checker (.*);

`default_nettype wire
